// File: sv/gsc_pkg.sv
package gsc_pkg;

	// Pipeline depth of the stick path, from the entry register to the last stage
	localparam int STICK_LAT = 48;
	// Deadzone rescale result stays below 2^13, radius clamp result below 2^7
	localparam int DZ_BITS = 13;
	localparam int CL_BITS = 7;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_LEFT_DZ  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RIGHT_DZ = 2'd1;

	localparam logic [6:0]         STICK_RANGE  = 7'd127;
	localparam logic [6:0]         DZ_MAX       = 7'd126;
	localparam logic [14:0]        RANGE_SQ     = 15'd16129;
	localparam logic signed [15:0] TRIGGER_DEAD = 16'sd400;
	localparam logic signed [15:0] HAT_LEVEL    = 16'sd20000;
	localparam logic signed [15:0] HALF_FULL    = 16'sd16000;

	// Deadzone search lane: both axes of one stick
	typedef struct packed {
		logic [14:0] a2x;
		logic [14:0] a2y;
		logic [43:0] bsqx;
		logic [43:0] bsqy;
		logic [14:0] d2;
		logic [6:0]  s;
		logic [12:0] lox;
		logic [12:0] loy;
		logic [19:0] px;
		logic [19:0] py;
		logic        negx;
		logic        negy;
		logic [6:0]  mx;
		logic [6:0]  my;
		logic        bypass;
		logic        dead;
	} dz_t;

	typedef struct packed {
		dz_t         d;
		logic        posx;
		logic        posy;
		logic [29:0] asqx;
		logic [29:0] asqy;
	} dz_mid_t;

	// Radius clamp search lane
	typedef struct packed {
		logic [12:0] mx;
		logic [12:0] my;
		logic        negx;
		logic        negy;
		logic        clamp;
		logic [26:0] d2;
		logic [41:0] lhsx;
		logic [41:0] lhsy;
		logic [6:0]  lox;
		logic [6:0]  loy;
	} cl_t;

	typedef struct packed {
		cl_t         c;
		logic [15:0] ksqx;
		logic [15:0] ksqy;
	} cl_mid_t;

	typedef struct packed {
		logic signed [15:0] lt;
		logic signed [15:0] rt;
		logic [3:0]         hat;
	} side_t;

	typedef struct packed {
		logic signed [15:0] left_h;
		logic signed [15:0] left_v;
		logic signed [15:0] right_h;
		logic signed [15:0] right_v;
		logic signed [15:0] left_trigger;
		logic signed [15:0] right_trigger;
		logic [13:0]        virtual_buttons;
	} result_t;

	// floor(t/127) for t < 16256: t = 128a + b = 127a + (a + b)
	function automatic logic [6:0] div127(input logic [13:0] t);
		logic [7:0] sum;
		sum = {1'b0, t[13:7]} + {1'b0, t[6:0]};
		return t[13:7] + ((sum >= 8'd127) ? 7'd1 : 7'd0);
	endfunction

	// trunc(c*32000/127) = 251c + floor(123c/127)
	function automatic logic [15:0] full_scale(input logic [6:0] c);
		logic [15:0] base;
		logic [13:0] rem;
		base = 16'(c) * 16'd251;
		rem  = 14'(c) * 14'd123;
		return base + 16'(div127(rem));
	endfunction

	// trunc(raw*127/32768)
	function automatic logic signed [7:0] quant127(input logic signed [15:0] raw);
		logic signed [23:0] p;
		p = $signed({{8{raw[15]}}, raw}) * 24'sd127;
		if (p < 0)
			p = p + 24'sd32767;
		p = p >>> 15;
		return p[7:0];
	endfunction

	// trunc(raw*32000/32768) = trunc(raw*125/128)
	function automatic logic signed [15:0] to_full(input logic signed [15:0] raw);
		logic signed [23:0] p;
		p = $signed({{8{raw[15]}}, raw}) * 24'sd125;
		if (p < 0)
			p = p + 24'sd127;
		p = p >>> 7;
		return p[15:0];
	endfunction

	function automatic logic [3:0] dir_bits(input logic signed [15:0] a,
			input logic signed [15:0] b);
		return {b < -HALF_FULL, b > HALF_FULL, a < -HALF_FULL, a > HALF_FULL};
	endfunction

endpackage

// File: sv/gsc_in_if.sv
interface gsc_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] left_h_raw;
	logic signed [15:0] left_v_raw;
	logic signed [15:0] right_h_raw;
	logic signed [15:0] right_v_raw;
	logic signed [15:0] left_trigger_raw;
	logic signed [15:0] right_trigger_raw;
	logic signed [15:0] hat_h_raw;
	logic signed [15:0] hat_v_raw;

	modport source(output valid, left_h_raw, left_v_raw, right_h_raw, right_v_raw,
		left_trigger_raw, right_trigger_raw, hat_h_raw, hat_v_raw, input ready);
	modport sink(input valid, left_h_raw, left_v_raw, right_h_raw, right_v_raw,
		left_trigger_raw, right_trigger_raw, hat_h_raw, hat_v_raw, output ready);
endinterface

// File: sv/gsc_out_if.sv
interface gsc_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] left_h;
	logic signed [15:0] left_v;
	logic signed [15:0] right_h;
	logic signed [15:0] right_v;
	logic signed [15:0] left_trigger;
	logic signed [15:0] right_trigger;
	logic [13:0]        virtual_buttons;

	modport source(output valid, left_h, left_v, right_h, right_v, left_trigger,
		right_trigger, virtual_buttons, input ready);
	modport sink(input valid, left_h, left_v, right_h, right_v, left_trigger,
		right_trigger, virtual_buttons, output ready);
endinterface

// File: sv/gsc_cfg_if.sv
interface gsc_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [6:0]  data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// File: sv/gsc_dz_step.sv
module gsc_dz_step #(
	parameter int BIT = 0
) (
	input  logic           clk,
	input  logic           en,
	input  gsc_pkg::dz_t   d_in,
	output gsc_pkg::dz_t   d_out
);

	gsc_pkg::dz_mid_t mid_s1;
	gsc_pkg::dz_t     d_s2;

	logic [24:0] ax, ay;
	logic        posx, posy;
	logic [44:0] prodx, prody;
	logic        okx, oky;

	// Candidate a = 2*m*127 - (2n-1)*s with n = lo + 2^BIT, from the running lo*s
	always_comb begin
		ax = 25'(d_in.a2x) + 25'(d_in.s) - (25'(d_in.px) << 1) - (25'(d_in.s) << (BIT + 1));
		ay = 25'(d_in.a2y) + 25'(d_in.s) - (25'(d_in.py) << 1) - (25'(d_in.s) << (BIT + 1));
		posx = !ax[24] && (ax != 25'd0);
		posy = !ay[24] && (ay != 25'd0);
	end

	// Square the candidate
	always_ff @(posedge clk) begin
		if (en) begin
			mid_s1.d    <= d_in;
			mid_s1.posx <= posx;
			mid_s1.posy <= posy;
			mid_s1.asqx <= posx ? 30'(ax[14:0]) * 30'(ax[14:0]) : 30'd0;
			mid_s1.asqy <= posy ? 30'(ay[14:0]) * 30'(ay[14:0]) : 30'd0;
		end
	end

	// Compare d2*a^2 against b^2
	always_comb begin
		prodx = 45'(mid_s1.asqx) * 45'(mid_s1.d.d2);
		prody = 45'(mid_s1.asqy) * 45'(mid_s1.d.d2);
		okx = mid_s1.posx && (prodx >= 45'(mid_s1.d.bsqx));
		oky = mid_s1.posy && (prody >= 45'(mid_s1.d.bsqy));
	end

	// Keep the bit where the predicate holds
	always_ff @(posedge clk) begin
		if (en) begin
			d_s2 <= mid_s1.d;
			if (okx) begin
				d_s2.lox <= mid_s1.d.lox | (13'd1 << BIT);
				d_s2.px  <= mid_s1.d.px + (20'(mid_s1.d.s) << BIT);
			end
			if (oky) begin
				d_s2.loy <= mid_s1.d.loy | (13'd1 << BIT);
				d_s2.py  <= mid_s1.d.py + (20'(mid_s1.d.s) << BIT);
			end
		end
	end

	assign d_out = d_s2;

endmodule

// File: sv/gsc_clamp_step.sv
module gsc_clamp_step #(
	parameter int BIT = 0
) (
	input  logic          clk,
	input  logic          en,
	input  gsc_pkg::cl_t  c_in,
	output gsc_pkg::cl_t  c_out
);

	gsc_pkg::cl_mid_t mid_s1;
	gsc_pkg::cl_t     c_s2;

	logic [6:0]  nx, ny;
	logic [7:0]  kx, ky;
	logic [42:0] prodx, prody;

	// Odd bound k = 2n-1 for candidate n
	always_comb begin
		nx = c_in.lox | (7'd1 << BIT);
		ny = c_in.loy | (7'd1 << BIT);
		kx = (8'(nx) << 1) - 8'd1;
		ky = (8'(ny) << 1) - 8'd1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mid_s1.c    <= c_in;
			mid_s1.ksqx <= 16'(kx) * 16'(kx);
			mid_s1.ksqy <= 16'(ky) * 16'(ky);
		end
	end

	always_comb begin
		prodx = 43'(mid_s1.ksqx) * 43'(mid_s1.c.d2);
		prody = 43'(mid_s1.ksqy) * 43'(mid_s1.c.d2);
	end

	// Keep the bit where (2*m*127)^2 >= k^2*d2
	always_ff @(posedge clk) begin
		if (en) begin
			c_s2 <= mid_s1.c;
			if (43'(mid_s1.c.lhsx) >= prodx)
				c_s2.lox <= mid_s1.c.lox | (7'd1 << BIT);
			if (43'(mid_s1.c.lhsy) >= prody)
				c_s2.loy <= mid_s1.c.loy | (7'd1 << BIT);
		end
	end

	assign c_out = c_s2;

endmodule

// File: sv/gsc_stick.sv
module gsc_stick (
	input  logic               clk,
	input  logic               en,
	input  logic signed [15:0] h,
	input  logic signed [15:0] v,
	input  logic [6:0]         r,
	output logic signed [15:0] oh,
	output logic signed [15:0] ov
);

	logic signed [7:0] x_s1, y_s1;
	logic [6:0]        r_s1;
	gsc_pkg::dz_t      dz_s2, dz_s3, dz_s4;
	gsc_pkg::dz_t      dz_chain [gsc_pkg::DZ_BITS+1];
	gsc_pkg::cl_t      cl_s31, cl_s32, cl_s33;
	gsc_pkg::cl_t      cl_chain [gsc_pkg::CL_BITS+1];
	logic signed [15:0] oh_s48, ov_s48;

	logic signed [15:0] nv;
	logic [7:0]         negx1, negy1;
	logic [6:0]         mx1, my1;
	logic [14:0]        d2_1;
	logic [6:0]         cx, cy;
	logic [15:0]        fx, fy;

	// Negate vertical with saturation
	assign nv = (v == 16'sh8000) ? 16'sh7fff : -v;

	// Quantize to the 127 grid
	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= gsc_pkg::quant127(h);
			y_s1 <= gsc_pkg::quant127(nv);
			r_s1 <= (r == gsc_pkg::STICK_RANGE) ? gsc_pkg::DZ_MAX : r;
		end
	end

	// Magnitudes, radius squared and deadzone test
	always_comb begin
		negx1 = -x_s1;
		negy1 = -y_s1;
		mx1   = x_s1[7] ? negx1[6:0] : x_s1[6:0];
		my1   = y_s1[7] ? negy1[6:0] : y_s1[6:0];
		d2_1  = 15'(mx1) * 15'(mx1) + 15'(my1) * 15'(my1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dz_s2.a2x    <= 15'(mx1) * 15'd254;
			dz_s2.a2y    <= 15'(my1) * 15'd254;
			dz_s2.bsqx   <= '0;
			dz_s2.bsqy   <= '0;
			dz_s2.d2     <= d2_1;
			dz_s2.s      <= gsc_pkg::STICK_RANGE - r_s1;
			dz_s2.lox    <= '0;
			dz_s2.loy    <= '0;
			dz_s2.px     <= '0;
			dz_s2.py     <= '0;
			dz_s2.negx   <= x_s1[7];
			dz_s2.negy   <= y_s1[7];
			dz_s2.mx     <= mx1;
			dz_s2.my     <= my1;
			dz_s2.bypass <= (r_s1 == 7'd0);
			dz_s2.dead   <= d2_1 < (15'(r_s1) * 15'(r_s1));
		end
	end

	// b = 2*m*127*r, then b^2
	always_ff @(posedge clk) begin
		if (en) begin
			dz_s3      <= dz_s2;
			dz_s3.bsqx <= 44'(22'(dz_s2.a2x) * 22'(gsc_pkg::STICK_RANGE - dz_s2.s));
			dz_s3.bsqy <= 44'(22'(dz_s2.a2y) * 22'(gsc_pkg::STICK_RANGE - dz_s2.s));
			dz_s4      <= dz_s3;
			dz_s4.bsqx <= 44'(dz_s3.bsqx[21:0]) * 44'(dz_s3.bsqx[21:0]);
			dz_s4.bsqy <= 44'(dz_s3.bsqy[21:0]) * 44'(dz_s3.bsqy[21:0]);
		end
	end

	// Deadzone rescale: one result bit per step, MSB first
	assign dz_chain[0] = dz_s4;
	for (genvar i = 0; i < gsc_pkg::DZ_BITS; i++) begin : g_dz
		gsc_dz_step #(.BIT(gsc_pkg::DZ_BITS - 1 - i)) u_step (
			.clk   (clk),
			.en    (en),
			.d_in  (dz_chain[i]),
			.d_out (dz_chain[i+1])
		);
	end

	// Pick bypass, zero or rescaled magnitude
	always_ff @(posedge clk) begin
		if (en) begin
			cl_s31 <= '0;
			cl_s31.negx <= dz_chain[gsc_pkg::DZ_BITS].negx;
			cl_s31.negy <= dz_chain[gsc_pkg::DZ_BITS].negy;
			if (dz_chain[gsc_pkg::DZ_BITS].bypass) begin
				cl_s31.mx <= 13'(dz_chain[gsc_pkg::DZ_BITS].mx);
				cl_s31.my <= 13'(dz_chain[gsc_pkg::DZ_BITS].my);
			end else if (!dz_chain[gsc_pkg::DZ_BITS].dead) begin
				cl_s31.mx <= dz_chain[gsc_pkg::DZ_BITS].lox;
				cl_s31.my <= dz_chain[gsc_pkg::DZ_BITS].loy;
			end
		end
	end

	// New radius squared and 2*m*127, then its square
	always_ff @(posedge clk) begin
		if (en) begin
			cl_s32       <= cl_s31;
			cl_s32.d2    <= 27'(cl_s31.mx) * 27'(cl_s31.mx) + 27'(cl_s31.my) * 27'(cl_s31.my);
			cl_s32.lhsx  <= 42'(21'(cl_s31.mx) * 21'd254);
			cl_s32.lhsy  <= 42'(21'(cl_s31.my) * 21'd254);
			cl_s33       <= cl_s32;
			cl_s33.clamp <= cl_s32.d2 > 27'(gsc_pkg::RANGE_SQ);
			cl_s33.lhsx  <= 42'(cl_s32.lhsx[20:0]) * 42'(cl_s32.lhsx[20:0]);
			cl_s33.lhsy  <= 42'(cl_s32.lhsy[20:0]) * 42'(cl_s32.lhsy[20:0]);
		end
	end

	assign cl_chain[0] = cl_s33;
	for (genvar i = 0; i < gsc_pkg::CL_BITS; i++) begin : g_cl
		gsc_clamp_step #(.BIT(gsc_pkg::CL_BITS - 1 - i)) u_step (
			.clk   (clk),
			.en    (en),
			.c_in  (cl_chain[i]),
			.c_out (cl_chain[i+1])
		);
	end

	// Scale to full range and restore sign
	always_comb begin
		cx = cl_chain[gsc_pkg::CL_BITS].clamp ? cl_chain[gsc_pkg::CL_BITS].lox
			: cl_chain[gsc_pkg::CL_BITS].mx[6:0];
		cy = cl_chain[gsc_pkg::CL_BITS].clamp ? cl_chain[gsc_pkg::CL_BITS].loy
			: cl_chain[gsc_pkg::CL_BITS].my[6:0];
		fx = gsc_pkg::full_scale(cx);
		fy = gsc_pkg::full_scale(cy);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			oh_s48 <= cl_chain[gsc_pkg::CL_BITS].negx ? -$signed(fx) : $signed(fx);
			ov_s48 <= cl_chain[gsc_pkg::CL_BITS].negy ? -$signed(fy) : $signed(fy);
		end
	end

	assign oh = oh_s48;
	assign ov = ov_s48;

endmodule

// File: sv/gamepad_stick_conditioner_core.sv
// Throughput: one sample per cycle while the skid entry is free; the stick path is a
// 48-stage pipeline whose deadzone search takes two stages per result bit over 13 bits.
// A two-entry output (register plus skid) keeps input ready high until both fill.
// Reset clears the valid bits, the output handshake state and both deadzone radii.
module gamepad_stick_conditioner_core (
	input logic         clk,
	input logic         arst_n,
	gsc_in_if.sink      sample,
	gsc_out_if.source   result,
	gsc_cfg_if.sink     cfg
);

	localparam int LAT = gsc_pkg::STICK_LAT;

	logic [6:0]              left_dz_q, right_dz_q;
	logic                    en;
	logic [LAT-1:0]          vld_s;
	gsc_pkg::side_t          side_s [LAT];
	gsc_pkg::side_t          side_in;
	logic signed [15:0]      lh, lv, rh, rv;
	logic signed [15:0]      lt_full, rt_full, hx, hy;
	gsc_pkg::result_t        res;
	gsc_pkg::result_t        out_q, skid_q;
	logic                    out_v_q, skid_v_q;
	logic                    take, free, load_pipe;

	// Configuration writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_dz_q  <= '0;
			right_dz_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				gsc_pkg::REG_LEFT_DZ:  left_dz_q  <= cfg.data;
				gsc_pkg::REG_RIGHT_DZ: right_dz_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// Advance the whole pipe while the skid entry is free
	assign en           = !skid_v_q;
	assign sample.ready = en;

	gsc_stick u_left (
		.clk (clk),
		.en  (en),
		.h   (sample.left_h_raw),
		.v   (sample.left_v_raw),
		.r   (left_dz_q),
		.oh  (lh),
		.ov  (lv)
	);

	gsc_stick u_right (
		.clk (clk),
		.en  (en),
		.h   (sample.right_h_raw),
		.v   (sample.right_v_raw),
		.r   (right_dz_q),
		.oh  (rh),
		.ov  (rv)
	);

	// Triggers and hat are done at entry, then ride along with the stick stages
	always_comb begin
		lt_full = gsc_pkg::to_full(sample.left_trigger_raw);
		rt_full = gsc_pkg::to_full(sample.right_trigger_raw);
		hx      = gsc_pkg::to_full(sample.hat_h_raw);
		hy      = gsc_pkg::to_full(sample.hat_v_raw);
		side_in.lt = (lt_full >= gsc_pkg::TRIGGER_DEAD || lt_full <= -gsc_pkg::TRIGGER_DEAD)
			? lt_full : 16'sd0;
		side_in.rt = (rt_full >= gsc_pkg::TRIGGER_DEAD || rt_full <= -gsc_pkg::TRIGGER_DEAD)
			? rt_full : 16'sd0;
		side_in.hat = {hx > gsc_pkg::HAT_LEVEL, hx < -gsc_pkg::HAT_LEVEL,
			hy > gsc_pkg::HAT_LEVEL, hy < -gsc_pkg::HAT_LEVEL};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s <= '0;
		else if (en)
			vld_s <= {vld_s[LAT-2:0], sample.valid};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= side_in;
			for (int i = 1; i < LAT; i++)
				side_s[i] <= side_s[i-1];
		end
	end

	// Assemble the result and the direction buttons
	always_comb begin
		res.left_h          = lh;
		res.left_v          = lv;
		res.right_h         = rh;
		res.right_v         = rv;
		res.left_trigger    = side_s[LAT-1].lt;
		res.right_trigger   = side_s[LAT-1].rt;
		res.virtual_buttons = {gsc_pkg::dir_bits(rh, rv), gsc_pkg::dir_bits(lh, lv),
			side_s[LAT-1].rt > gsc_pkg::HALF_FULL, side_s[LAT-1].lt > gsc_pkg::HALF_FULL,
			side_s[LAT-1].hat};
	end

	// Output register with one skid entry
	assign take      = out_v_q && result.ready;
	assign free      = !out_v_q || take;
	assign load_pipe = en && vld_s[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (free) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end
		end else if (load_pipe) begin
			if (free)
				out_v_q <= 1'b1;
			else
				skid_v_q <= 1'b1;
		end else if (take) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q && free)
			out_q <= skid_q;
		else if (!skid_v_q && load_pipe && free)
			out_q <= res;
		if (!skid_v_q && load_pipe && !free)
			skid_q <= res;
	end

	assign result.valid           = out_v_q;
	assign result.left_h          = out_q.left_h;
	assign result.left_v          = out_q.left_v;
	assign result.right_h         = out_q.right_h;
	assign result.right_v         = out_q.right_v;
	assign result.left_trigger    = out_q.left_trigger;
	assign result.right_trigger   = out_q.right_trigger;
	assign result.virtual_buttons = out_q.virtual_buttons;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry full while output register empty");

	a_pipe_lands: assert property (@(posedge clk) disable iff (!arst_n)
		load_pipe |=> out_v_q)
		else $error("finished sample dropped at the output");

	a_stick_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> (out_q.left_h <= 16'sd32000 && out_q.left_h >= -16'sd32000 &&
			out_q.right_v <= 16'sd32000 && out_q.right_v >= -16'sd32000))
		else $error("stick output outside full scale");

endmodule

// File: tb/sv/tb_if.sv
// The channel interfaces are declared with the RTL; this file names the
// sample transfer type the testbench drives into the input channel.
package tb_gsc_pkg;
	typedef struct packed {
		logic signed [15:0] left_h_raw;
		logic signed [15:0] left_v_raw;
		logic signed [15:0] right_h_raw;
		logic signed [15:0] right_v_raw;
		logic signed [15:0] left_trigger_raw;
		logic signed [15:0] right_trigger_raw;
		logic signed [15:0] hat_h_raw;
		logic signed [15:0] hat_v_raw;
	} sample_t;
endpackage

// File: tb/sv/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	gsc_in_if  sample();
	gsc_out_if result();
	gsc_cfg_if cfg();

	gamepad_stick_conditioner_core dut (
		.clk(clk), .arst_n(arst_n), .sample(sample), .result(result), .cfg(cfg)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Testbench copy of the deadzone registers
	int unsigned              left_radius, right_radius;
	gsc_pkg::result_t         expected_results[$];
	int                       mismatch_count = 0;
	bit                       hold_off = 1'b0;
	bit                       burst_go = 1'b0;
	bit                       stim_done = 1'b0;

	function automatic longint magnitude(longint c);
		return c < 0 ? -c : c;
	endfunction

	// Rounded deadzone rescale, half away from zero, by bisection
	function automatic longint rescale_axis(longint c, longint d2, longint r);
		longint m, b, lo, hi, n, a;
		m = magnitude(c);
		lo = 0;
		hi = 16130;
		if (m == 0)
			return 0;
		b = 2 * m * 127 * r;
		while (hi - lo > 1) begin
			n = (lo + hi) / 2;
			a = 2 * m * 127 - (2 * n - 1) * (127 - r);
			if (a > 0 && d2 * a * a >= b * b)
				lo = n;
			else
				hi = n;
		end
		return c < 0 ? -lo : lo;
	endfunction

	// Rounded clamp onto radius 127
	function automatic longint clamp_axis(longint c, longint d2);
		longint lhs, lo, hi, n, k;
		lhs = 2 * magnitude(c) * 127;
		lhs = lhs * lhs;
		lo = 0;
		hi = 128;
		while (hi - lo > 1) begin
			n = (lo + hi) / 2;
			k = 2 * n - 1;
			if (lhs >= k * k * d2)
				lo = n;
			else
				hi = n;
		end
		return c < 0 ? -lo : lo;
	endfunction

	function automatic void shape_stick(input longint h, input longint v,
			input int unsigned radius, output logic signed [15:0] oh,
			output logic signed [15:0] ov);
		longint nv, x, y, d2, r, nx, ny;
		nv = -v;
		if (nv > 32767)
			nv = 32767;
		x = h * 127 / 32768;
		y = nv * 127 / 32768;
		r = radius & 7'h7f;
		if (r > 126)
			r = 126;
		if (r != 0) begin
			d2 = x * x + y * y;
			if (d2 < r * r) begin
				x = 0;
				y = 0;
			end else begin
				nx = rescale_axis(x, d2, r);
				ny = rescale_axis(y, d2, r);
				x = nx;
				y = ny;
			end
		end
		d2 = x * x + y * y;
		if (d2 > 127 * 127) begin
			nx = clamp_axis(x, d2);
			ny = clamp_axis(y, d2);
			x = nx;
			y = ny;
		end
		oh = 16'(x * 32000 / 127);
		ov = 16'(y * 32000 / 127);
	endfunction

	function automatic longint full_level(longint raw);
		return raw * 32000 / 32768;
	endfunction

	function automatic logic [3:0] direction_bits(longint a, longint b);
		return {b < -16000, b > 16000, a < -16000, a > 16000};
	endfunction

	function automatic gsc_pkg::result_t condition_sample(tb_gsc_pkg::sample_t s);
		gsc_pkg::result_t e;
		longint lt, rt, hx, hy;
		logic signed [15:0] oh, ov;
		shape_stick(s.left_h_raw, s.left_v_raw, left_radius, oh, ov);
		e.left_h = oh;
		e.left_v = ov;
		shape_stick(s.right_h_raw, s.right_v_raw, right_radius, oh, ov);
		e.right_h = oh;
		e.right_v = ov;
		lt = full_level(s.left_trigger_raw);
		rt = full_level(s.right_trigger_raw);
		if (lt < 400 && lt > -400) lt = 0;
		if (rt < 400 && rt > -400) rt = 0;
		hx = full_level(s.hat_h_raw);
		hy = full_level(s.hat_v_raw);
		e.left_trigger = 16'(lt);
		e.right_trigger = 16'(rt);
		e.virtual_buttons = {direction_bits(e.right_h, e.right_v),
			direction_bits(e.left_h, e.left_v), rt > 16000, lt > 16000,
			hx > 20000, hx < -20000, hy > 20000, hy < -20000};
		return e;
	endfunction

	// Directed rows; a nonzero check flag means the typed result is also compared
	typedef struct {
		tb_gsc_pkg::sample_t s;
		bit                  check;
		gsc_pkg::result_t    r;
	} row_t;

	function automatic tb_gsc_pkg::sample_t pack_sample(int lh, int lv, int rh, int rv,
			int lt, int rt, int hh, int hv);
		tb_gsc_pkg::sample_t s;
		s = {16'(lh), 16'(lv), 16'(rh), 16'(rv), 16'(lt), 16'(rt), 16'(hh), 16'(hv)};
		return s;
	endfunction

	// Send one sample with a random gap before it; drop valid only across a gap
	task automatic send_sample(input tb_gsc_pkg::sample_t s, input bit typed,
			input gsc_pkg::result_t r);
		int gap;
		gsc_pkg::result_t e;
		gap = $urandom_range(0, 7);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		if (gap != 0) begin
			sample.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample.valid <= 1'b1;
		{sample.left_h_raw, sample.left_v_raw, sample.right_h_raw, sample.right_v_raw,
			sample.left_trigger_raw, sample.right_trigger_raw, sample.hat_h_raw,
			sample.hat_v_raw} <= s;
		do @(posedge clk); while (!sample.ready);
		e = condition_sample(s);
		if (typed && e != r) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("typed row disagrees with predictor: %h vs %h", r, e);
		end
		expected_results.push_back(e);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [6:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= value;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		if (idx == gsc_pkg::REG_LEFT_DZ)
			left_radius = value;
		else
			right_radius = value;
		@(posedge clk);
	endtask

	// Stop offering and wait until every expected result has arrived
	task automatic drain();
		sample.valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic signed [15:0] random_axis();
		case ($urandom_range(0, 4))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'($urandom_range(0, 2000)) - 16'sd1000;
			default: return 16'($urandom);
		endcase
	endfunction

	// Stimulus
	initial begin
		row_t             rows[$];
		gsc_pkg::result_t zero;
		logic [6:0]       radius_set[5];
		sample.valid = 1'b0;
		{sample.left_h_raw, sample.left_v_raw, sample.right_h_raw, sample.right_v_raw,
			sample.left_trigger_raw, sample.right_trigger_raw, sample.hat_h_raw,
			sample.hat_v_raw} = '0;
		cfg.valid = 1'b0;
		cfg.index = gsc_pkg::REG_LEFT_DZ;
		cfg.data = '0;
		left_radius = 0;
		right_radius = 0;
		radius_set = '{7'd0, 7'd126, 7'd127, 7'd1, 7'd40};
		zero = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows: rest, extremes, thresholds, saturating negation
		rows.push_back('{pack_sample(0, 0, 0, 0, 0, 0, 0, 0), 1'b1, zero});
		rows.push_back('{pack_sample(32767, 32767, 32767, 32767, 32767, 32767,
			32767, 32767), 1'b0, zero});
		rows.push_back('{pack_sample(-32768, -32768, -32768, -32768, -32768, -32768,
			-32768, -32768), 1'b0, zero});
		rows.push_back('{pack_sample(32767, 0, 0, -32768, 409, -410, 20972, -20972),
			1'b0, zero});
		rows.push_back('{pack_sample(23170, 23170, -23170, -23170, 420, 16778,
			20971, -20971), 1'b0, zero});
		rows.push_back('{pack_sample(16777, -16777, 16, 8, 16384, -16384,
			20480, -20480), 1'b0, zero});
		foreach (rows[i])
			send_sample(rows[i].s, rows[i].check, rows[i].r);
		drain();

		// Deadzone settings including both extremes and the aliased top value
		foreach (radius_set[k]) begin
			write_reg(gsc_pkg::REG_LEFT_DZ, radius_set[k]);
			write_reg(gsc_pkg::REG_RIGHT_DZ, radius_set[(k + 2) % 5]);
			repeat (3) begin
				send_sample(pack_sample(32767, -32768, 300 * k, 0, 0, 0, 0, 0), 1'b0, zero);
				send_sample(pack_sample(-32768, 32767, 0, 12000 * k, 0, 0, 0, 0),
					1'b0, zero);
			end
			drain();
		end

		// Random samples with fresh radii every 100 items
		for (int n = 0; n < 600; n++) begin
			tb_gsc_pkg::sample_t s;
			if (n % 100 == 0) begin
				drain();
				write_reg(gsc_pkg::REG_LEFT_DZ, 7'($urandom));
				write_reg(gsc_pkg::REG_RIGHT_DZ, 7'($urandom));
			end
			// Start the long receiver hold-off while plenty of items remain to offer
			if (n == 110)
				burst_go = 1'b1;
			s = {random_axis(), random_axis(), random_axis(), random_axis(),
				random_axis(), random_axis(), random_axis(), random_axis()};
			send_sample(s, 1'b0, zero);
		end
		sample.valid <= 1'b0;
		stim_done = 1'b1;
	end

	// Long receiver hold-off to fill the pipeline, counted on its own
	initial begin
		wait (burst_go);
		hold_off = 1'b1;
		repeat (400) @(posedge clk);
		hold_off = 1'b0;
	end

	// Receiver: random stalls, stretches of steady ready
	initial begin
		int stall;
		result.ready = 1'b0;
		wait (arst_n);
		forever begin
			stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
			if (stall != 0 || hold_off) begin
				result.ready <= 1'b0;
				repeat (stall) @(posedge clk);
				while (hold_off)
					@(posedge clk);
			end
			result.ready <= 1'b1;
			do @(posedge clk); while (!result.valid);
		end
	end

	// Compare each transfer with the oldest expectation
	always @(posedge clk) begin
		gsc_pkg::result_t got, e;
		if (arst_n && result.valid && result.ready) begin
			got = {result.left_h, result.left_v, result.right_h, result.right_v,
				result.left_trigger, result.right_trigger, result.virtual_buttons};
			if (expected_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result %h", got);
			end else begin
				e = expected_results.pop_front();
				if (got != e) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display({"mismatch: expected lh %0d lv %0d rh %0d rv %0d ",
							"lt %0d rt %0d btn %h, got lh %0d lv %0d rh %0d rv %0d ",
							"lt %0d rt %0d btn %h"},
							e.left_h, e.left_v, e.right_h, e.right_v, e.left_trigger,
							e.right_trigger, e.virtual_buttons, got.left_h, got.left_v,
							got.right_h, got.right_v, got.left_trigger, got.right_trigger,
							got.virtual_buttons);
				end
			end
		end
	end

	// Finish once everything has arrived
	initial begin
		wait (stim_done);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Watchdog
	initial begin
		#2ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
